[sv/assert_macros.svh]
// Assertion macros shared by the corner classifier RTL.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/pcc_pkg.sv]
// Shared types and constants of the polyline corner classifier.
// No dependencies.
package pcc_pkg;

  localparam int COORD_W   = 32;
  localparam int CNT_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int Q15_W     = 16;
  localparam int ZT_W      = 32;
  localparam int TSQ_W     = 64;
  localparam int ACC_W     = 160;
  localparam int MB_W      = 65;

  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHORS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEMANTIC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ZTSQ     = 3'd5;

  typedef enum logic [4:0] {
    OP_TIX, OP_TIY, OP_TOX, OP_TOY,
    OP_TX, OP_TY, OP_LA1, OP_LA2, OP_LB1, OP_LB2,
    OP_P, OP_S2,
    OP_R1S, OP_R2S, OP_R1M, OP_R2M, OP_R1L, OP_R2L
  } op_t;

  typedef enum logic [2:0] {
    PH_WIN, PH_LAST, PH_FIRST, PH_N0, PH_N1A, PH_N1B
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_WAIT, S_SETUP, S_EMIT, S_UPDATE
  } state_t;

  typedef struct packed {
    logic   latch;
    logic   start;
    logic   capture;
    logic   setup;
    logic   emit;
    logic   update;
    op_t    op;
    phase_t phase;
  } cmd_t;

  typedef struct packed {
    logic       mul_busy;
    logic       mul_done;
    logic       out_free;
    logic       last;
    logic [1:0] seen;
  } sts_t;

endpackage

[sv/pcc_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on pcc_pkg.
module pcc_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pcc_pkg::ACC_W-1:0] a,
  input  logic [pcc_pkg::MB_W-1:0]  b,
  output logic                      busy,
  output logic                      done,
  output logic [pcc_pkg::ACC_W-1:0] prod
);
  import pcc_pkg::*;

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] a_r;
  logic [MB_W-1:0]  b_r;
  logic             busy_r;

  assign busy = busy_r;
  assign done = busy_r && (b_r == '0);
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

endmodule

[sv/pcc_dp.sv]
// Datapath: configuration, path window, operand setup, multiplier and output register.
// Depends on pcc_pkg and pcc_mul.
module pcc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcc_pkg::cmd_t                 cmd,
  output pcc_pkg::sts_t                 sts,
  input  logic                          cfg_valid,
  input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcc_pkg::ZT_W-1:0]      cfg_data,
  input  logic signed [31:0]            in_point_x,
  input  logic signed [31:0]            in_point_y,
  input  logic signed [31:0]            in_in_tan_x,
  input  logic signed [31:0]            in_in_tan_y,
  input  logic signed [31:0]            in_out_tan_x,
  input  logic signed [31:0]            in_out_tan_y,
  input  logic                          in_last_vertex,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pcc_pkg::CNT_W-1:0]     out_vertex_number,
  output logic                          out_sharp,
  output logic                          out_tangent_locked,
  output logic                          out_last_result
);
  import pcc_pkg::*;

  function automatic logic [COORD_W:0] mag33(logic signed [COORD_W:0] v);
    return v[COORD_W] ? (COORD_W+1)'(-v) : (COORD_W+1)'(v);
  endfunction

  function automatic logic [COORD_W-1:0] mag32(logic signed [COORD_W-1:0] v);
    return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
  endfunction

  function automatic logic [Q15_W-1:0] rmag(logic signed [Q15_W-1:0] r);
    return r[Q15_W-1] ? Q15_W'(-r) : Q15_W'(r);
  endfunction

  function automatic logic reach(logic signed [Q15_W-1:0] r, logic negd,
                                 logic [ACC_W-1:0] lhs, logic [ACC_W-1:0] rhs);
    if (!r[Q15_W-1]) begin
      return !negd && (lhs >= rhs);
    end
    return !negd || (lhs <= rhs);
  endfunction

  logic                     closed_r, anchors_r;
  logic signed [Q15_W-1:0]  sharp_cos_r, sem_cos_r, lock_cos_r;
  logic [ZT_W-1:0]          ztsq_r;

  logic signed [COORD_W-1:0] px_r, py_r, itx_r, ity_r, otx_r, oty_r;
  logic                      last_r;

  logic signed [COORD_W-1:0] first_r [4];
  logic signed [COORD_W-1:0] win_r [4];
  logic                      z0_r, z1_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [1:0]                seen_r;

  logic [TSQ_W-1:0]  tsq_i_r, tsq_o_r;
  logic [COORD_W:0]  amx_r, amy_r, bmx_r, bmy_r;
  logic              sx_r, sy_r, zseg_r, endp_r, zsel_r;
  logic [TSQ_W-1:0]  tx_r, ty_r;
  logic [MB_W-1:0]   la_r, lb_r;
  logic [129:0]      p_r;
  logic [ACC_W-1:0]  lhs_r, q_r;
  logic              rs_r, rsem_r, rl_r;

  logic                  out_valid_r;
  logic [CNT_W-1:0]      onum_r;
  logic                  osharp_r, olock_r, olast_r;

  logic                  ztan;
  logic [MB_W-1:0]       d;
  logic                  dneg, negd;
  logic [ACC_W-1:0]      mul_a, prod;
  logic [MB_W-1:0]       mul_b;
  logic                  mul_busy, mul_done;
  logic signed [COORD_W-1:0] pvx, pvy, cx, cy, nx, ny;
  logic                  zs, ep;
  logic signed [COORD_W:0] ax, ay, bx, by;
  logic                  cue, cls_sharp, cls_lock, e_flag;
  logic [CNT_W-1:0]      num_sel;
  logic                  sharp_sel, lock_sel, fin_sel;

  assign ztan = (tsq_i_r <= TSQ_W'(ztsq_r)) && (tsq_o_r <= TSQ_W'(ztsq_r));

  always_comb begin
    if (sx_r == sy_r) begin
      d    = {1'b0, tx_r} + {1'b0, ty_r};
      dneg = sx_r;
    end else if (tx_r >= ty_r) begin
      d    = {1'b0, tx_r - ty_r};
      dneg = sx_r;
    end else begin
      d    = {1'b0, ty_r - tx_r};
      dneg = sy_r;
    end
  end
  assign negd = dneg && (d != '0);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op) inside
      OP_TIX: begin mul_a = ACC_W'(mag32(itx_r)); mul_b = MB_W'(mag32(itx_r)); end
      OP_TIY: begin mul_a = ACC_W'(mag32(ity_r)); mul_b = MB_W'(mag32(ity_r)); end
      OP_TOX: begin mul_a = ACC_W'(mag32(otx_r)); mul_b = MB_W'(mag32(otx_r)); end
      OP_TOY: begin mul_a = ACC_W'(mag32(oty_r)); mul_b = MB_W'(mag32(oty_r)); end
      OP_TX:  begin mul_a = ACC_W'(amx_r); mul_b = MB_W'(bmx_r); end
      OP_TY:  begin mul_a = ACC_W'(amy_r); mul_b = MB_W'(bmy_r); end
      OP_LA1: begin mul_a = ACC_W'(amx_r); mul_b = MB_W'(amx_r); end
      OP_LA2: begin mul_a = ACC_W'(amy_r); mul_b = MB_W'(amy_r); end
      OP_LB1: begin mul_a = ACC_W'(bmx_r); mul_b = MB_W'(bmx_r); end
      OP_LB2: begin mul_a = ACC_W'(bmy_r); mul_b = MB_W'(bmy_r); end
      OP_P:   begin mul_a = ACC_W'(la_r); mul_b = lb_r; end
      OP_S2:  begin mul_a = ACC_W'(d); mul_b = d; end
      OP_R1S: begin mul_a = ACC_W'(p_r); mul_b = MB_W'(rmag(sharp_cos_r)); end
      OP_R2S: begin mul_a = q_r; mul_b = MB_W'(rmag(sharp_cos_r)); end
      OP_R1M: begin mul_a = ACC_W'(p_r); mul_b = MB_W'(rmag(sem_cos_r)); end
      OP_R2M: begin mul_a = q_r; mul_b = MB_W'(rmag(sem_cos_r)); end
      OP_R1L: begin mul_a = ACC_W'(p_r); mul_b = MB_W'(rmag(lock_cos_r)); end
      OP_R2L: begin mul_a = q_r; mul_b = MB_W'(rmag(lock_cos_r)); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  pcc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      unique case (cmd.op) inside
        OP_TIX: tsq_i_r <= prod[TSQ_W-1:0];
        OP_TIY: tsq_i_r <= tsq_i_r + prod[TSQ_W-1:0];
        OP_TOX: tsq_o_r <= prod[TSQ_W-1:0];
        OP_TOY: tsq_o_r <= tsq_o_r + prod[TSQ_W-1:0];
        OP_TX:  tx_r <= prod[TSQ_W-1:0];
        OP_TY:  ty_r <= prod[TSQ_W-1:0];
        OP_LA1: la_r <= {1'b0, prod[TSQ_W-1:0]};
        OP_LA2: la_r <= la_r + {1'b0, prod[TSQ_W-1:0]};
        OP_LB1: lb_r <= {1'b0, prod[TSQ_W-1:0]};
        OP_LB2: lb_r <= lb_r + {1'b0, prod[TSQ_W-1:0]};
        OP_P:   p_r <= prod[129:0];
        OP_S2:  lhs_r <= {prod[129:0], 30'b0};
        OP_R1S, OP_R1M, OP_R1L: q_r <= prod;
        OP_R2S: rs_r <= reach(sharp_cos_r, negd, lhs_r, prod);
        OP_R2M: rsem_r <= reach(sem_cos_r, negd, lhs_r, prod);
        OP_R2L: rl_r <= reach(lock_cos_r, negd, lhs_r, prod);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.phase)
      PH_LAST: begin
        pvx = win_r[2]; pvy = win_r[3]; cx = px_r; cy = py_r;
        nx = first_r[0]; ny = first_r[1]; zs = ztan; ep = !closed_r;
      end
      PH_FIRST: begin
        pvx = px_r; pvy = py_r; cx = first_r[0]; cy = first_r[1];
        nx = first_r[2]; ny = first_r[3]; zs = z0_r; ep = !closed_r;
      end
      default: begin
        pvx = win_r[0]; pvy = win_r[1]; cx = win_r[2]; cy = win_r[3];
        nx = px_r; ny = py_r; zs = z1_r; ep = 1'b0;
      end
    endcase
  end

  assign ax = {pvx[COORD_W-1], pvx} - {cx[COORD_W-1], cx};
  assign ay = {pvy[COORD_W-1], pvy} - {cy[COORD_W-1], cy};
  assign bx = {nx[COORD_W-1], nx} - {cx[COORD_W-1], cx};
  assign by = {ny[COORD_W-1], ny} - {cy[COORD_W-1], cy};

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      amx_r  <= mag33(ax);
      amy_r  <= mag33(ay);
      bmx_r  <= mag33(bx);
      bmy_r  <= mag33(by);
      sx_r   <= ax[COORD_W] ^ bx[COORD_W];
      sy_r   <= ay[COORD_W] ^ by[COORD_W];
      zseg_r <= ((ax == '0) && (ay == '0)) || ((bx == '0) && (by == '0));
      endp_r <= ep;
      zsel_r <= zs;
    end
  end

  assign cue       = zsel_r && rsem_r;
  assign cls_sharp = anchors_r && (endp_r || (!zseg_r && (rs_r || cue)));
  assign cls_lock  = anchors_r && (endp_r || (!zseg_r && (rl_r || cue)));
  assign e_flag    = anchors_r && !closed_r;

  always_comb begin
    unique case (cmd.phase)
      PH_WIN:   begin num_sel = cnt_r - 1'b1; sharp_sel = cls_sharp; lock_sel = cls_lock;
                      fin_sel = 1'b0; end
      PH_LAST:  begin num_sel = cnt_r; sharp_sel = cls_sharp; lock_sel = cls_lock;
                      fin_sel = 1'b0; end
      PH_FIRST: begin num_sel = '0; sharp_sel = cls_sharp; lock_sel = cls_lock;
                      fin_sel = 1'b1; end
      PH_N0:    begin num_sel = cnt_r; sharp_sel = 1'b0; lock_sel = 1'b0; fin_sel = 1'b1; end
      PH_N1A:   begin num_sel = cnt_r; sharp_sel = e_flag; lock_sel = e_flag;
                      fin_sel = 1'b0; end
      default:  begin num_sel = '0; sharp_sel = e_flag; lock_sel = e_flag; fin_sel = 1'b1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r    <= 1'b0;
      anchors_r   <= 1'b1;
      sharp_cos_r <= -16'sd16384;
      sem_cos_r   <= -16'sd30792;
      lock_cos_r  <= -16'sd23170;
      ztsq_r      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CLOSED:   closed_r    <= cfg_data[0];
        CFG_ANCHORS:  anchors_r   <= cfg_data[0];
        CFG_SHARP:    sharp_cos_r <= cfg_data[Q15_W-1:0];
        CFG_SEMANTIC: sem_cos_r   <= cfg_data[Q15_W-1:0];
        CFG_LOCK:     lock_cos_r  <= cfg_data[Q15_W-1:0];
        CFG_ZTSQ:     ztsq_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      px_r   <= in_point_x;
      py_r   <= in_point_y;
      itx_r  <= in_in_tan_x;
      ity_r  <= in_in_tan_y;
      otx_r  <= in_out_tan_x;
      oty_r  <= in_out_tan_y;
      last_r <= in_last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.update && last_r)) begin
      for (int i = 0; i < 4; i++) begin
        first_r[i] <= '0;
        win_r[i]   <= '0;
      end
      z0_r   <= 1'b0;
      z1_r   <= 1'b0;
      cnt_r  <= '0;
      seen_r <= '0;
    end else if (cmd.update) begin
      win_r[0] <= win_r[2];
      win_r[1] <= win_r[3];
      win_r[2] <= px_r;
      win_r[3] <= py_r;
      z1_r     <= ztan;
      cnt_r    <= cnt_r + 1'b1;
      if (seen_r != 2'd3) begin
        seen_r <= seen_r + 1'b1;
      end
      if (seen_r == 2'd0) begin
        first_r[0] <= px_r;
        first_r[1] <= py_r;
        z0_r       <= ztan;
      end else if (seen_r == 2'd1) begin
        first_r[2] <= px_r;
        first_r[3] <= py_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      onum_r   <= num_sel;
      osharp_r <= sharp_sel;
      olock_r  <= lock_sel;
      olast_r  <= fin_sel;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_vertex_number  = onum_r;
  assign out_sharp          = osharp_r;
  assign out_tangent_locked = olock_r;
  assign out_last_result    = olast_r;

  assign sts.mul_busy = mul_busy;
  assign sts.mul_done = mul_done;
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.last     = last_r;
  assign sts.seen     = seen_r;

endmodule

[sv/pcc_ctrl.sv]
// Controller: sequences tangent checks, classifications, emits and path update.
// Depends on pcc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pcc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output pcc_pkg::cmd_t cmd,
  input  pcc_pkg::sts_t sts
);
  import pcc_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  phase_t phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_TIX;
      phase_r <= PH_WIN;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.op    = op_r;
    cmd.phase = phase_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          op_nxt    = OP_TIX;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sts.mul_done) begin
          cmd.capture = 1'b1;
          if (op_r == OP_TOY) begin
            if (sts.seen >= 2'd2) begin
              phase_nxt = PH_WIN;
              state_nxt = S_SETUP;
            end else if (!sts.last) begin
              state_nxt = S_UPDATE;
            end else if (sts.seen == 2'd0) begin
              phase_nxt = PH_N0;
              state_nxt = S_EMIT;
            end else begin
              phase_nxt = PH_N1A;
              state_nxt = S_EMIT;
            end
          end else if (op_r == OP_R2L) begin
            state_nxt = S_EMIT;
          end else begin
            op_nxt    = op_t'(op_r + 5'd1);
            state_nxt = S_ISSUE;
          end
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        op_nxt    = OP_TX;
        state_nxt = S_ISSUE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          unique case (phase_r)
            PH_WIN: begin
              if (sts.last) begin
                phase_nxt = PH_LAST;
                state_nxt = S_SETUP;
              end else begin
                state_nxt = S_UPDATE;
              end
            end
            PH_LAST: begin
              phase_nxt = PH_FIRST;
              state_nxt = S_SETUP;
            end
            PH_N1A: phase_nxt = PH_N1B;
            default: state_nxt = S_UPDATE;
          endcase
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `PCC_ASSERT_IMP(a_start_free, cmd.start, !sts.mul_busy, "multiply started while busy")
  `PCC_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free, "emit into occupied output")
  `PCC_ASSERT_NXT(a_accept_issue, in_valid && in_ready, state_r == S_ISSUE, "accept lost")
  `PCC_ASSERT_IMP(a_capture_done, cmd.capture, sts.mul_done, "capture without product")

endmodule

[sv/polyline_corner_classifier_top.sv]
// Top level of the polyline corner classifier.
// Depends on pcc_pkg, pcc_ctrl and pcc_dp.
//
// Usage: vertices enter on the in_ channel (valid/ready), one item per vertex,
// with in_last_vertex marking the end of a path. Results leave on the out_
// channel (valid/ready): vertex k-1 as vertex k >= 2 arrives, and on the last
// vertex the last two vertices and then vertex 0 with out_last_result set.
// Registers are to be written on the cfg_ channel, always ready, only while
// idle; the block does not enforce this. Each item runs through one shared
// shift-add multiplier, one product at a time, tangent checks before the
// classifications; the next item is taken after its update. Reset clears the
// path state and loads register defaults. When the receiver stalls the result
// is held in the output register and the block waits.
module polyline_corner_classifier_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcc_pkg::ZT_W-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            in_point_x,
  input  logic signed [31:0]            in_point_y,
  input  logic signed [31:0]            in_in_tan_x,
  input  logic signed [31:0]            in_in_tan_y,
  input  logic signed [31:0]            in_out_tan_x,
  input  logic signed [31:0]            in_out_tan_y,
  input  logic                          in_last_vertex,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pcc_pkg::CNT_W-1:0]     out_vertex_number,
  output logic                          out_sharp,
  output logic                          out_tangent_locked,
  output logic                          out_last_result
);
  import pcc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pcc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_point_x         (in_point_x),
    .in_point_y         (in_point_y),
    .in_in_tan_x        (in_in_tan_x),
    .in_in_tan_y        (in_in_tan_y),
    .in_out_tan_x       (in_out_tan_x),
    .in_out_tan_y       (in_out_tan_y),
    .in_last_vertex     (in_last_vertex),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_vertex_number  (out_vertex_number),
    .out_sharp          (out_sharp),
    .out_tangent_locked (out_tangent_locked),
    .out_last_result    (out_last_result)
  );

endmodule
